// ===== sv/uf_pkg.sv =====
// ----------------------------------------------------------------------------
// uf_pkg
// Shared widths and the controller state type for the union-find engine.
// ----------------------------------------------------------------------------
package uf_pkg;

   localparam int ELEM_W = 10;
   localparam int SIZE_W = 11;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_COMP_RD,
      ST_COMP_WR,
      ST_SIZE_A_RD,
      ST_SIZE_A_CHK,
      ST_SIZE_B_RD,
      ST_SIZE_B_CHK,
      ST_LINK,
      ST_DONE
   } state_type;

endpackage

// ===== sv/uf_ram.sv =====
// ----------------------------------------------------------------------------
// uf_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module uf_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/union_find_engine.sv =====
// ----------------------------------------------------------------------------
// union_find_engine
// Items are handled one at a time: the next item is taken once the result
//   is loaded into the output register, and a held result stalls that load.
//   An elem_a out of range goes straight to the result.
// Reset: a clearing pass over all NUM_ELEMENTS entries sets every parent to
//   itself and every size to one; no item is accepted until it finishes.
// ----------------------------------------------------------------------------
module union_find_engine #(
   parameter int NUM_ELEMENTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // elem_a [9:0], elem_b [19:10], zero [23:20]
   input  logic        req_tuser,   // cmd [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // root [9:0], set_size [20:10], merged [21], zero [23:22]
);

   localparam int AW = $clog2(NUM_ELEMENTS);
   localparam int EW = uf_pkg::ELEM_W;
   localparam int SW = uf_pkg::SIZE_W;

   function automatic logic [AW-1:0] to_addr(input logic [EW-1:0] e);
      logic [AW+EW-1:0] x;
      x = {{AW{1'b0}}, e};
      return x[AW-1:0];
   endfunction

   function automatic logic [EW-1:0] to_elem(input logic [AW-1:0] a);
      logic [AW+EW-1:0] x;
      x = {{EW{1'b0}}, a};
      return x[EW-1:0];
   endfunction

   function automatic logic in_range(input logic [EW-1:0] e);
      return ({{(32-EW){1'b0}}, e} < 32'(NUM_ELEMENTS));
   endfunction

   uf_pkg::state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic          cmd_ff, cmd_in;
   logic [EW-1:0] elem_b_ff, elem_b_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [EW-1:0] start_ff, start_in;
   logic [EW-1:0] root_ff, root_in;
   logic [EW-1:0] ra_ff, ra_in;
   logic [EW-1:0] rb_ff, rb_in;
   logic [SW-1:0] size_a_ff, size_a_in;
   logic [SW-1:0] size_b_ff, size_b_in;
   logic          phase_b_ff, phase_b_in;
   logic [EW-1:0] res_root_ff, res_root_in;
   logic [SW-1:0] res_size_ff, res_size_in;
   logic          res_merged_ff, res_merged_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0] rsp_root_ff, rsp_root_in;
   logic [SW-1:0] rsp_size_ff, rsp_size_in;
   logic          rsp_merged_ff, rsp_merged_in;

   logic          par_wr_en, par_rd_en, cnt_wr_en, cnt_rd_en;
   logic [AW-1:0] par_wr_addr, par_rd_addr, cnt_wr_addr, cnt_rd_addr;
   logic [EW-1:0] par_wr_data, par_rd_data;
   logic [SW-1:0] cnt_wr_data, cnt_rd_data;

   logic [EW-1:0] req_elem_a, req_elem_b;
   logic          req_take, out_free, a_small, clr_last;
   logic [EW-1:0] link_big, link_small;
   logic [SW-1:0] size_sum;

   assign req_elem_a = req_tdata[9:0];
   assign req_elem_b = req_tdata[19:10];
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clr_last   = (clr_ff == AW'(NUM_ELEMENTS - 1));
   assign a_small    = (size_a_ff < size_b_ff);
   assign link_big   = a_small ? rb_ff : ra_ff;
   assign link_small = a_small ? ra_ff : rb_ff;
   assign size_sum   = size_a_ff + size_b_ff;

   uf_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(EW)) u_parent (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (par_wr_addr),
      .wr_data (par_wr_data),
      .rd_en   (par_rd_en),
      .rd_addr (par_rd_addr),
      .rd_data (par_rd_data)
   );

   uf_ram #(.DEPTH(NUM_ELEMENTS), .WIDTH(SW)) u_count (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uf_pkg::ST_CLEAR: begin
            if (clr_last) state_in = uf_pkg::ST_IDLE;
         end
         uf_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = in_range(req_elem_a) ? uf_pkg::ST_WALK_RD : uf_pkg::ST_DONE;
            end
         end
         uf_pkg::ST_WALK_RD: state_in = uf_pkg::ST_WALK_CHK;
         uf_pkg::ST_WALK_CHK: begin
            state_in = (par_rd_data == cur_ff) ? uf_pkg::ST_COMP_RD : uf_pkg::ST_WALK_RD;
         end
         uf_pkg::ST_COMP_RD: begin
            if (cur_ff != root_ff) begin
               state_in = uf_pkg::ST_COMP_WR;
            end else if (!phase_b_ff) begin
               state_in = uf_pkg::ST_SIZE_A_RD;
            end else if (root_ff == ra_ff) begin
               state_in = uf_pkg::ST_DONE;
            end else begin
               state_in = uf_pkg::ST_SIZE_B_RD;
            end
         end
         uf_pkg::ST_COMP_WR:    state_in = uf_pkg::ST_COMP_RD;
         uf_pkg::ST_SIZE_A_RD:  state_in = uf_pkg::ST_SIZE_A_CHK;
         uf_pkg::ST_SIZE_A_CHK: begin
            state_in = (cmd_ff && in_range(elem_b_ff)) ? uf_pkg::ST_WALK_RD : uf_pkg::ST_DONE;
         end
         uf_pkg::ST_SIZE_B_RD:  state_in = uf_pkg::ST_SIZE_B_CHK;
         uf_pkg::ST_SIZE_B_CHK: state_in = uf_pkg::ST_LINK;
         uf_pkg::ST_LINK:       state_in = uf_pkg::ST_DONE;
         uf_pkg::ST_DONE: begin
            if (out_free) state_in = uf_pkg::ST_IDLE;
         end
         default: state_in = uf_pkg::ST_IDLE;
      endcase
   end

   // outputs: memory ports and handshake
   always_comb begin
      req_tready  = 1'b0;
      par_wr_en   = 1'b0;
      par_wr_addr = to_addr(cur_ff);
      par_wr_data = root_ff;
      par_rd_en   = 1'b0;
      par_rd_addr = to_addr(cur_ff);
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = to_addr(link_big);
      cnt_wr_data = size_sum;
      cnt_rd_en   = 1'b0;
      cnt_rd_addr = to_addr(ra_ff);
      case (state_ff)
         uf_pkg::ST_CLEAR: begin
            par_wr_en   = 1'b1;
            par_wr_addr = clr_ff;
            par_wr_data = to_elem(clr_ff);
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = SW'(1);
         end
         uf_pkg::ST_IDLE:      req_tready = 1'b1;
         uf_pkg::ST_WALK_RD:   par_rd_en  = 1'b1;
         uf_pkg::ST_COMP_RD:   par_rd_en  = (cur_ff != root_ff);
         uf_pkg::ST_COMP_WR:   par_wr_en  = 1'b1;
         uf_pkg::ST_SIZE_A_RD: cnt_rd_en  = 1'b1;
         uf_pkg::ST_SIZE_B_RD: begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = to_addr(rb_ff);
         end
         uf_pkg::ST_LINK: begin
            par_wr_en   = 1'b1;
            par_wr_addr = to_addr(link_small);
            par_wr_data = link_big;
            cnt_wr_en   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      elem_b_in     = elem_b_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      size_a_in     = size_a_ff;
      size_b_in     = size_b_ff;
      phase_b_in    = phase_b_ff;
      res_root_in   = res_root_ff;
      res_size_in   = res_size_ff;
      res_merged_in = res_merged_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_root_in   = rsp_root_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_merged_in = rsp_merged_ff;
      case (state_ff)
         uf_pkg::ST_CLEAR: clr_in = clr_ff + AW'(1);
         uf_pkg::ST_IDLE: begin
            if (req_take) begin
               cmd_in        = req_tuser;
               elem_b_in     = req_elem_b;
               cur_in        = req_elem_a;
               start_in      = req_elem_a;
               phase_b_in    = 1'b0;
               res_root_in   = req_elem_a;
               res_size_in   = SW'(1);
               res_merged_in = 1'b0;
            end
         end
         uf_pkg::ST_WALK_CHK: begin
            if (par_rd_data == cur_ff) begin
               root_in = cur_ff;
               cur_in  = start_ff;
            end else begin
               cur_in  = par_rd_data;
            end
         end
         uf_pkg::ST_COMP_RD: begin
            if (cur_ff == root_ff) begin
               if (!phase_b_ff) begin
                  ra_in = root_ff;
               end else begin
                  rb_in         = root_ff;
                  res_root_in   = ra_ff;
                  res_size_in   = size_a_ff;
                  res_merged_in = 1'b0;
               end
            end
         end
         uf_pkg::ST_COMP_WR: cur_in = par_rd_data;
         uf_pkg::ST_SIZE_A_CHK: begin
            size_a_in     = cnt_rd_data;
            res_root_in   = ra_ff;
            res_size_in   = cnt_rd_data;
            res_merged_in = 1'b0;
            phase_b_in    = 1'b1;
            cur_in        = elem_b_ff;
            start_in      = elem_b_ff;
         end
         uf_pkg::ST_SIZE_B_CHK: size_b_in = cnt_rd_data;
         uf_pkg::ST_LINK: begin
            res_root_in   = link_big;
            res_size_in   = size_sum;
            res_merged_in = 1'b1;
         end
         uf_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = res_root_ff;
               rsp_size_in   = res_size_ff;
               rsp_merged_in = res_merged_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      elem_b_ff     <= elem_b_in;
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      size_a_ff     <= size_a_in;
      size_b_ff     <= size_b_in;
      phase_b_ff    <= phase_b_in;
      res_root_ff   <= res_root_in;
      res_size_ff   <= res_size_in;
      res_merged_ff <= res_merged_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_merged_ff, rsp_size_ff, rsp_root_ff};

`ifndef NO_ASSERTIONS
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == uf_pkg::ST_CLEAR |-> !req_tready)
      else $error("item taken during clearing pass");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != uf_pkg::ST_IDLE)
      else $error("controller idle right after taking an item");

   a_link_distinct: assert property (@(posedge clock) disable iff (reset)
      state_ff == uf_pkg::ST_LINK |-> cmd_ff && (ra_ff != rb_ff))
      else $error("link of equal roots or on a find");

   a_comp_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == uf_pkg::ST_COMP_WR |-> cur_ff != root_ff)
      else $error("relink of the root itself");

   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_size_ff != '0)
      else $error("zero set size in result");
`endif

endmodule

// ===== tb/tb_union_find_engine.sv =====
// ----------------------------------------------------------------------------
// tb_union_find_engine
// Self-checking bench for the disjoint-set engine. Find and unite items are
// streamed in, the expected root, set size and merge flag are predicted with
// union by size and path compression, and every result is checked in order.
// Directed unions come first (ties, same-set unites, multi-hop paths), then
// random traffic in three phases with different idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_union_find_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW           = uf_pkg::ELEM_W;
   localparam int SW           = uf_pkg::SIZE_W;
   localparam int NUM_ELEMENTS = 1024;
   localparam bit OP_FIND      = 1'b0;
   localparam bit OP_UNITE     = 1'b1;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 64;
   localparam int PHASE_ITEMS  = 410;
   localparam int WINDOW       = 48;

   typedef struct packed {
      logic [EW-1:0] root;
      logic [SW-1:0] set_size;
      logic          merged;
   } dsu_result_type;

   class dsu_scoreboard;
      logic [EW-1:0]  link_of [NUM_ELEMENTS];
      logic [SW-1:0]  members_of [NUM_ELEMENTS];
      dsu_result_type awaited [$];
      int errors   = 0;
      int finds    = 0;
      int unites   = 0;
      int merges   = 0;
      int same_set = 0;
      int checked  = 0;
      int biggest  = 0;

      function new();
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            link_of[i]    = EW'(i);
            members_of[i] = SW'(1);
         end
      endfunction

      function logic [EW-1:0] root_of(logic [EW-1:0] e);
         logic [EW-1:0] r;
         logic [EW-1:0] nxt;
         r = e;
         while (link_of[r] != r)
            r = link_of[r];
         while (e != r) begin
            nxt        = link_of[e];
            link_of[e] = r;
            e          = nxt;
         end
         return r;
      endfunction

      function void note_request(bit op, logic [EW-1:0] a, logic [EW-1:0] b);
         dsu_result_type res;
         logic [EW-1:0]  ra;
         logic [EW-1:0]  rb;
         ra           = root_of(a);
         res.root     = ra;
         res.set_size = members_of[ra];
         res.merged   = 1'b0;
         if (op == OP_UNITE) begin
            unites++;
            rb = root_of(b);
            if (rb == ra) begin
               same_set++;
            end else begin
               if (members_of[ra] < members_of[rb]) begin
                  link_of[ra]     = rb;
                  members_of[rb] += members_of[ra];
                  res.root        = rb;
               end else begin
                  link_of[rb]     = ra;
                  members_of[ra] += members_of[rb];
                  res.root        = ra;
               end
               res.set_size = members_of[res.root];
               res.merged   = 1'b1;
               merges++;
            end
         end else begin
            finds++;
         end
         if (res.set_size > biggest)
            biggest = res.set_size;
         awaited = {awaited, res};
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [23:0] word);
         dsu_result_type want;
         dsu_result_type got;
         got.root     = word[9:0];
         got.set_size = word[20:10];
         got.merged   = word[21];
         if (awaited.size() == 0) begin
            report_mismatch($sformatf("result %h with none outstanding", word));
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.root != want.root)
            report_mismatch($sformatf("item %0d root %0d, want %0d",
                                      checked, got.root, want.root));
         if (got.set_size != want.set_size)
            report_mismatch($sformatf("item %0d set_size %0d, want %0d",
                                      checked, got.set_size, want.set_size));
         if (got.merged != want.merged)
            report_mismatch($sformatf("item %0d merged %0b, want %0b",
                                      checked, got.merged, want.merged));
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // elem_a [9:0], elem_b [19:10], zero [23:20]
   logic        req_tuser  = 1'b0; // cmd [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // root [9:0], set_size [20:10], merged [21], zero [23:22]

   int send_idle_pct = 9;
   int recv_idle_pct = 73;
   int quiet_cycles  = 0;

   dsu_scoreboard sb = new();

   union_find_engine #(
      .NUM_ELEMENTS(NUM_ELEMENTS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, sb.awaited.size());
         $display("tb_union_find_engine failed");
         $finish;
      end
   end

   task automatic send_item(input bit op, input logic [EW-1:0] a,
                            input logic [EW-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {4'b0000, b, a};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, a, b);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sb.awaited.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [EW-1:0] pick_elem(int base);
      if ($urandom_range(99) < 70)
         return EW'(base + $urandom_range(WINDOW - 1));
      return EW'($urandom_range(NUM_ELEMENTS - 1));
   endfunction

   task automatic run_random(int s_pct, int r_pct);
      int base;
      bit op;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      base          = $urandom_range(NUM_ELEMENTS - WINDOW);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 100 == 99)
            base = $urandom_range(NUM_ELEMENTS - WINDOW);
         op = ($urandom_range(99) < 55) ? OP_UNITE : OP_FIND;
         send_item(op, pick_elem(base), pick_elem(base));
      end
      drain_results();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_item(OP_FIND,  10'd0,    10'd1023);
      send_item(OP_FIND,  10'd1023, 10'd0);
      send_item(OP_UNITE, 10'd0,    10'd1023);
      send_item(OP_FIND,  10'd1023, 10'd1023);
      send_item(OP_UNITE, 10'd1023, 10'd0);
      send_item(OP_UNITE, 10'd5,    10'd5);
      send_item(OP_UNITE, 10'd1,    10'd2);
      send_item(OP_UNITE, 10'd3,    10'd1);
      send_item(OP_UNITE, 10'd1023, 10'd3);
      send_item(OP_FIND,  10'd1023, 10'd0);
      send_item(OP_UNITE, 10'h155,  10'h2AA);
      send_item(OP_UNITE, 10'd10,   10'd11);
      send_item(OP_UNITE, 10'd12,   10'd13);
      send_item(OP_UNITE, 10'd10,   10'd12);
      send_item(OP_UNITE, 10'd14,   10'd15);
      send_item(OP_UNITE, 10'd16,   10'd17);
      send_item(OP_UNITE, 10'd14,   10'd16);
      send_item(OP_UNITE, 10'd10,   10'd14);
      send_item(OP_FIND,  10'd17,   10'h3FF);
      send_item(OP_UNITE, 10'd17,   10'd13);
      send_item(OP_UNITE, 10'h2AA,  10'd1022);
      send_item(OP_FIND,  10'h155,  10'd0);
      drain_results();

      run_random(9, 73);
      run_random(73, 9);
      run_random(0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results: %0d finds, %0d unites (%0d merged, %0d same set)",
               sb.checked, sb.finds, sb.unites, sb.merges, sb.same_set);
      $display("largest set reached %0d elements, %0d mismatches", sb.biggest, sb.errors);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("tb_union_find_engine passed");
      else
         $display("tb_union_find_engine failed");
      $finish;
   end

endmodule
